// ===== rtl/err_pkg.sv =====
// ----------------------------------------------------------------------------
// err_pkg: shared types and constants of the event rule router table
// Request codes, rule status codes and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package err_pkg;

  typedef enum logic [2:0] {
    REQ_WRITE      = 3'd0,
    REQ_SIGNAL     = 3'd1,
    REQ_DISPATCH   = 3'd2,
    REQ_FIND_FREE  = 3'd3,
    REQ_LOOKUP     = 3'd4,
    REQ_FIRST_USED = 3'd5,
    REQ_NEXT_USED  = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_e;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_ENABLED  = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 4;
  localparam int EVT_W    = 8;
  localparam int ACT_W    = 8;

endpackage

// ===== rtl/err_ram.sv =====
// ----------------------------------------------------------------------------
// err_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module err_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/event_rule_router_table_unit.sv =====
// ----------------------------------------------------------------------------
// event_rule_router_table_unit: table of event routing rules
// Rules live in one RAM; every request other than write and clear scans the
// table one entry per cycle, with read-modify-write for signal and dispatch.
// ----------------------------------------------------------------------------
//  channel   | ports                                              | dir
//  ----------+----------------------------------------------------+-----
//  request   | start, busy, req_type_i, rule_index_i,             | in
//            | rule_status_i, event_id_i, action_id_i             |
//  result    | result_valid_o, found_o, entry_index_o,            | out
//            | action_out_o, last_o                               |
//
// Write and clear-all are done in the accepting cycle; busy stays low.
// Other requests hold busy through S_SCAN (one RAM read per entry through
// the single read port), S_DRAIN (the last entry is processed) and S_RESULT
// (final result, none for signal). Dispatch results appear during the scan.
// Reset clears per-entry valid flags at once; an entry never written reads
// as free and zero, so no clearing pass is needed.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module event_rule_router_table_unit #(
  parameter int NUM_RULES = 16,
  parameter int ID_BITS   = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [err_pkg::REQ_W-1:0]    req_type_i,
  input  logic [err_pkg::IDX_W-1:0]    rule_index_i,
  input  logic [err_pkg::STATUS_W-1:0] rule_status_i,
  input  logic [err_pkg::EVT_W-1:0]    event_id_i,
  input  logic [err_pkg::ACT_W-1:0]    action_id_i,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic [err_pkg::IDX_W-1:0]    entry_index_o,
  output logic [err_pkg::ACT_W-1:0]    action_out_o,
  output logic                         last_o
);

  import err_pkg::*;

  localparam int RIDX_W = $clog2(NUM_RULES);
  localparam int EV_W   = (ID_BITS < EVT_W) ? ID_BITS : EVT_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EV_W-1:0]     evt;
    logic [ACT_W-1:0]    act;
    logic                pend;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_e;

  state_e               state_q;
  logic [NUM_RULES-1:0] valid_q;
  logic [RIDX_W-1:0]    rd_cnt_q;
  logic                 rd_valid_q;
  logic                 proc_vld_q;
  logic [RIDX_W-1:0]    proc_idx_q;
  req_e                 req_q;
  logic [IDX_W-1:0]     ridx_q;
  logic [EV_W-1:0]      ev_q;
  logic                 matched_q;
  logic                 held_vld_q;
  logic [IDX_W-1:0]     held_idx_q;
  logic [ACT_W-1:0]     held_act_q;

  logic                 out_vld_q;
  logic                 found_q;
  logic [IDX_W-1:0]     entry_idx_q;
  logic [ACT_W-1:0]     action_q;
  logic                 last_q;

  logic                 accept;
  req_e                 req_in;
  logic                 wr_en;
  logic [RIDX_W-1:0]    wr_addr;
  entry_t               wr_entry;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               rd_entry;
  logic                 is_used;
  logic                 is_enabled;
  logic                 ev_match;
  logic                 take_hit;
  logic [STATUS_W-1:0]  new_status;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign req_in  = req_e'(req_type_i);

  assign rd_entry   = rd_valid_q ? entry_t'(ram_rdata) : '0;
  assign is_used    = (rd_entry.status != ST_FREE);
  assign is_enabled = (rd_entry.status == ST_ENABLED);
  assign ev_match   = (rd_entry.evt == ev_q);
  assign new_status = (rule_status_i == ST_RESERVED) ? ST_DISABLED : rule_status_i;

  err_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_RULES)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .raddr_i (rd_cnt_q),
    .rdata_o (ram_rdata)
  );

  // Write port: host writes when idle, write-back of pending flags while scanning
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = proc_idx_q;
    wr_entry = rd_entry;
    if (accept && (req_in == REQ_WRITE)) begin
      wr_en           = (32'(rule_index_i) < 32'(NUM_RULES));
      wr_addr         = RIDX_W'(rule_index_i);
      wr_entry.status = new_status;
      wr_entry.evt    = event_id_i[EV_W-1:0];
      wr_entry.act    = action_id_i;
      wr_entry.pend   = 1'b0;
    end else if (proc_vld_q) begin
      if ((req_q == REQ_SIGNAL) && is_enabled && ev_match) begin
        wr_en         = 1'b1;
        wr_entry.pend = 1'b1;
      end else if ((req_q == REQ_DISPATCH) && is_enabled && rd_entry.pend) begin
        wr_en         = 1'b1;
        wr_entry.pend = 1'b0;
      end
    end
  end

  always_comb begin
    take_hit = 1'b0;
    if (proc_vld_q) begin
      case (req_q)
        REQ_DISPATCH:   take_hit = is_enabled && rd_entry.pend;
        REQ_FIND_FREE:  take_hit = !is_used && !held_vld_q;
        REQ_LOOKUP:     take_hit = ev_match && !matched_q && is_used;
        REQ_FIRST_USED: take_hit = is_used && !held_vld_q;
        REQ_NEXT_USED:  take_hit = is_used && !held_vld_q &&
                                   (32'(proc_idx_q) > 32'(ridx_q));
        default:        take_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      rd_valid_q  <= 1'b0;
      proc_vld_q  <= 1'b0;
      proc_idx_q  <= '0;
      req_q       <= REQ_WRITE;
      ridx_q      <= '0;
      ev_q        <= '0;
      matched_q   <= 1'b0;
      held_vld_q  <= 1'b0;
      held_idx_q  <= '0;
      held_act_q  <= '0;
      out_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      entry_idx_q <= '0;
      action_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      out_vld_q  <= 1'b0;
      proc_vld_q <= 1'b0;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req_in == REQ_CLEAR) begin
              valid_q <= '0;
            end else if (req_in != REQ_WRITE) begin
              req_q      <= req_in;
              ridx_q     <= rule_index_i;
              ev_q       <= event_id_i[EV_W-1:0];
              rd_cnt_q   <= '0;
              matched_q  <= 1'b0;
              held_vld_q <= 1'b0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          proc_vld_q <= 1'b1;
          proc_idx_q <= rd_cnt_q;
          rd_valid_q <= valid_q[rd_cnt_q];
          if (rd_cnt_q == RIDX_W'(NUM_RULES - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          state_q <= S_IDLE;
          if (req_q != REQ_SIGNAL) begin
            out_vld_q   <= 1'b1;
            found_q     <= held_vld_q;
            entry_idx_q <= held_vld_q ? held_idx_q : '0;
            action_q    <= held_vld_q ? held_act_q : '0;
            last_q      <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Lookup decides on the first matching entry only
      if (proc_vld_q && (req_q == REQ_LOOKUP) && ev_match) begin
        matched_q <= 1'b1;
      end

      // Hold the newest dispatch hit back so the final one can carry last
      if (take_hit) begin
        if ((req_q == REQ_DISPATCH) && held_vld_q) begin
          out_vld_q   <= 1'b1;
          found_q     <= 1'b1;
          entry_idx_q <= held_idx_q;
          action_q    <= held_act_q;
          last_q      <= 1'b0;
        end
        held_vld_q <= 1'b1;
        held_idx_q <= IDX_W'(proc_idx_q);
        held_act_q <= rd_entry.act;
      end
    end
  end

  assign result_valid_o = out_vld_q;
  assign found_o        = found_q;
  assign entry_index_o  = entry_idx_q;
  assign action_out_o   = action_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/err_checker.sv =====
// ----------------------------------------------------------------------------
// err_checker: port-level checks for the event rule router table
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module err_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [err_pkg::REQ_W-1:0]    req_type_i,
  input logic                         result_valid_o,
  input logic                         found_o,
  input logic [err_pkg::IDX_W-1:0]    entry_index_o,
  input logic [err_pkg::ACT_W-1:0]    action_out_o,
  input logic                         last_o
);

  import err_pkg::*;

  logic take;
  assign take = start && !busy;

  // Write and clear complete in the accepting cycle
  a_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ((req_type_i == REQ_WRITE) || (req_type_i == REQ_CLEAR)) |=> !busy)
    else $error("write or clear transaction left the block busy");

  // Scanning requests hold busy
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (req_type_i != REQ_WRITE) && (req_type_i != REQ_CLEAR) |=> busy)
    else $error("scanning transaction did not raise busy");

  // A miss is always a single, final, zeroed result
  a_miss_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !found_o |-> last_o && (entry_index_o == '0) &&
                                   (action_out_o == '0))
    else $error("not-found result is malformed");

  // No new result right after the final one of a request
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result follows the final result immediately");

endmodule

bind event_rule_router_table_unit err_checker u_err_checker (.*);

// ===== dv/event_rule_router_table_unit_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_rule_router_table_unit_chk: rule table predictor and result checker
// Keeps its own copy of the rule table, updated from every accepted request.
// It predicts the results of each request in order and compares every strobed
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module event_rule_router_table_unit_chk #(
  parameter int NUM_RULES = 16,
  parameter int ID_BITS   = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [err_pkg::REQ_W-1:0]    req_type_i,
  input  logic [err_pkg::IDX_W-1:0]    rule_index_i,
  input  logic [err_pkg::STATUS_W-1:0] rule_status_i,
  input  logic [err_pkg::EVT_W-1:0]    event_id_i,
  input  logic [err_pkg::ACT_W-1:0]    action_id_i,
  input  logic                         result_valid_i,
  input  logic                         found_i,
  input  logic [err_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [err_pkg::ACT_W-1:0]    action_out_i,
  input  logic                         last_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           result_count_o
);
  import err_pkg::*;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
    logic [ACT_W-1:0] action;
    logic             last;
  } route_result_t;

  localparam logic [EVT_W-1:0] ID_MASK = EVT_W'((1 << ID_BITS) - 1);

  logic [STATUS_W-1:0] rule_status_m [NUM_RULES];
  logic [EVT_W-1:0]    rule_event_m  [NUM_RULES];
  logic [ACT_W-1:0]    rule_action_m [NUM_RULES];
  logic                rule_pending_m[NUM_RULES];

  route_result_t route_results_q[$];
  int fail_count = 0;
  int result_count = 0;
  int pending_cnt = 0;

  assign fail_count_o   = fail_count;
  assign pending_o      = pending_cnt;
  assign result_count_o = result_count;

  task automatic clear_table();
    for (int i = 0; i < NUM_RULES; i++) begin
      rule_status_m[i]  = ST_FREE;
      rule_event_m[i]   = '0;
      rule_action_m[i]  = '0;
      rule_pending_m[i] = 1'b0;
    end
  endtask

  task automatic push_result(input logic hit, input int idx, input logic fin);
    route_result_t r;
    r.found  = hit;
    r.index  = hit ? IDX_W'(idx) : '0;
    r.action = hit ? rule_action_m[idx] : '0;
    r.last   = fin;
    route_results_q.push_back(r);
  endtask

  // Single-result requests: a negative index means not found.
  task automatic push_hit(input int idx);
    push_result(idx >= 0, idx, 1'b1);
  endtask

  function automatic int first_used_from(input int from);
    int hit;
    hit = -1;
    for (int i = from; i < NUM_RULES; i++) begin
      if (hit < 0 && rule_status_m[i] != ST_FREE) hit = i;
    end
    return hit;
  endfunction

  task automatic route_request(input req_e kind, input logic [IDX_W-1:0] idx,
                               input logic [STATUS_W-1:0] st,
                               input logic [EVT_W-1:0] ev,
                               input logic [ACT_W-1:0] act);
    logic [EVT_W-1:0] key;
    int hit;
    int match;
    int n;
    int k;
    key   = ev & ID_MASK;
    hit   = -1;
    match = -1;
    n     = 0;
    k     = 0;
    case (kind)
      REQ_WRITE: begin
        if (int'(idx) < NUM_RULES) begin
          rule_status_m[idx]  = (st == ST_RESERVED) ? ST_DISABLED : st;
          rule_event_m[idx]   = key;
          rule_action_m[idx]  = act;
          rule_pending_m[idx] = 1'b0;
        end
      end
      REQ_SIGNAL: begin
        for (int i = 0; i < NUM_RULES; i++) begin
          if (rule_status_m[i] == ST_ENABLED && rule_event_m[i] == key)
            rule_pending_m[i] = 1'b1;
        end
      end
      REQ_DISPATCH: begin
        for (int i = 0; i < NUM_RULES; i++) begin
          if (rule_status_m[i] == ST_ENABLED && rule_pending_m[i]) n++;
        end
        for (int i = 0; i < NUM_RULES; i++) begin
          if (rule_status_m[i] == ST_ENABLED && rule_pending_m[i]) begin
            rule_pending_m[i] = 1'b0;
            k++;
            push_result(1'b1, i, k == n);
          end
        end
        if (n == 0) push_hit(-1);
      end
      REQ_FIND_FREE: begin
        for (int i = 0; i < NUM_RULES; i++) begin
          if (hit < 0 && rule_status_m[i] == ST_FREE) hit = i;
        end
        push_hit(hit);
      end
      REQ_LOOKUP: begin
        // only the lowest matching entry counts, free or not
        for (int i = 0; i < NUM_RULES; i++) begin
          if (match < 0 && rule_event_m[i] == key) match = i;
        end
        if (match >= 0 && rule_status_m[match] != ST_FREE) hit = match;
        push_hit(hit);
      end
      REQ_FIRST_USED: push_hit(first_used_from(0));
      REQ_NEXT_USED:  push_hit(first_used_from(int'(idx) + 1));
      default:        clear_table();
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t want;
    if (!rst_ni) begin
      clear_table();
      route_results_q.delete();
    end else begin
      // compare first: a result never belongs to a request taken at the same edge
      if (result_valid_i) begin
        result_count++;
        if (route_results_q.size() == 0) begin
          $error("result with none expected: found %0d entry_index %0d action_out %0d last %0d",
                 found_i, entry_index_i, action_out_i, last_i);
          fail_count++;
        end else begin
          want = route_results_q.pop_front();
          check_field("found", want.found, found_i);
          check_field("entry_index", want.index, entry_index_i);
          check_field("action_out", want.action, action_out_i);
          check_field("last", want.last, last_i);
        end
      end
      if (start_i && !busy_i)
        route_request(req_e'(req_type_i), rule_index_i, rule_status_i, event_id_i,
                      action_id_i);
    end
    pending_cnt = route_results_q.size();
  end

endmodule

// ===== dv/tb_event_rule_router_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_rule_router_table_unit: testbench of the event rule router table
// Drives a directed sequence over every request kind and corner of the table,
// then random requests built around a small set of event ids so that signals
// and dispatches hit. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_event_rule_router_table_unit;
  import err_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 430;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [REQ_W-1:0]    req_type;
  logic [IDX_W-1:0]    rule_index;
  logic [STATUS_W-1:0] rule_status;
  logic [EVT_W-1:0]    event_id;
  logic [ACT_W-1:0]    action_id;
  logic                result_valid;
  logic                found;
  logic [IDX_W-1:0]    entry_index;
  logic [ACT_W-1:0]    action_out;
  logic                last;

  int fail_count;
  int pending;
  int result_count;
  int sent = 0;
  int directed_cnt = 0;
  int idle_cycles = 0;
  logic [EVT_W-1:0] event_pool[4];

  event_rule_router_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type),
    .rule_index_i  (rule_index),
    .rule_status_i (rule_status),
    .event_id_i    (event_id),
    .action_id_i   (action_id),
    .result_valid_o(result_valid),
    .found_o       (found),
    .entry_index_o (entry_index),
    .action_out_o  (action_out),
    .last_o        (last)
  );

  event_rule_router_table_unit_chk u_route_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_type_i    (req_type),
    .rule_index_i  (rule_index),
    .rule_status_i (rule_status),
    .event_id_i    (event_id),
    .action_id_i   (action_id),
    .result_valid_i(result_valid),
    .found_i       (found),
    .entry_index_i (entry_index),
    .action_out_i  (action_out),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .result_count_o(result_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Count cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Mostly ids from the pool so that signals, lookups and writes meet.
  function automatic logic [EVT_W-1:0] pick_event(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return event_pool[$urandom_range(0, 3)];
    return EVT_W'($urandom);
  endfunction

  task automatic issue_request(input req_e kind, input logic [IDX_W-1:0] idx,
                               input logic [STATUS_W-1:0] st,
                               input logic [EVT_W-1:0] ev,
                               input logic [ACT_W-1:0] act, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    req_type    <= kind;
    rule_index  <= idx;
    rule_status <= st;
    event_id    <= ev;
    action_id   <= act;
    // busy is stable between edges: sample it at the falling edge
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    sent++;
  endtask

  initial begin
    int roll;
    int gap;
    req_e kind;
    logic [STATUS_W-1:0] st;
    logic [EVT_W-1:0] ev;

    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type    = '0;
    rule_index  = '0;
    rule_status = '0;
    event_id    = '0;
    action_id   = '0;
    event_pool[0] = EVT_W'($urandom);
    event_pool[1] = EVT_W'($urandom);
    event_pool[2] = EVT_W'($urandom);
    event_pool[3] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: every search misses, lookup of id zero lands on a free entry.
    issue_request(REQ_FIND_FREE, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_FIRST_USED, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_NEXT_USED, 4'd15, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_LOOKUP, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_DISPATCH, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    // Populate: reserved status code stored as disabled.
    issue_request(REQ_WRITE, 4'd0, ST_ENABLED, 8'h11, 8'hFF, pick_gap());
    issue_request(REQ_WRITE, 4'd15, ST_ENABLED, 8'hFF, 8'h00, pick_gap());
    issue_request(REQ_WRITE, 4'd3, ST_RESERVED, 8'h11, 8'hAA, pick_gap());
    issue_request(REQ_WRITE, 4'd5, ST_DISABLED, 8'h80, 8'h01, pick_gap());
    issue_request(REQ_WRITE, 4'd7, ST_ENABLED, 8'h11, 8'h55, pick_gap());
    issue_request(REQ_SIGNAL, 4'd0, ST_FREE, 8'h11, 8'h00, pick_gap());
    issue_request(REQ_SIGNAL, 4'd0, ST_FREE, 8'hFF, 8'h00, pick_gap());
    // Rewrite drops the pending flag of the last entry.
    issue_request(REQ_WRITE, 4'd15, ST_ENABLED, 8'hFF, 8'h00, pick_gap());
    issue_request(REQ_DISPATCH, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_DISPATCH, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_LOOKUP, 4'd0, ST_FREE, 8'h11, 8'h00, pick_gap());
    issue_request(REQ_LOOKUP, 4'd0, ST_FREE, 8'h80, 8'h00, pick_gap());
    // A free entry ahead of the disabled one hides it from lookup.
    issue_request(REQ_WRITE, 4'd2, ST_FREE, 8'h80, 8'h7E, pick_gap());
    issue_request(REQ_LOOKUP, 4'd0, ST_FREE, 8'h80, 8'h00, pick_gap());
    issue_request(REQ_FIND_FREE, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_NEXT_USED, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_NEXT_USED, 4'd14, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_SIGNAL, 4'd0, ST_FREE, 8'hFF, 8'h00, pick_gap());
    issue_request(REQ_DISPATCH, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_CLEAR, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    issue_request(REQ_FIRST_USED, 4'd0, ST_FREE, 8'h00, 8'h00, pick_gap());
    directed_cnt = sent;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) kind = REQ_WRITE;
      else if (roll < 55) kind = REQ_SIGNAL;
      else if (roll < 70) kind = REQ_DISPATCH;
      else if (roll < 80) kind = REQ_LOOKUP;
      else if (roll < 85) kind = REQ_FIND_FREE;
      else if (roll < 90) kind = REQ_FIRST_USED;
      else if (roll < 97) kind = REQ_NEXT_USED;
      else kind = REQ_CLEAR;

      roll = $urandom_range(0, 99);
      if (roll < 70) st = ST_ENABLED;
      else if (roll < 85) st = ST_DISABLED;
      else if (roll < 95) st = ST_FREE;
      else st = ST_RESERVED;

      ev = pick_event(kind == REQ_LOOKUP ? 70 : 85);

      // Hold the sender until the block has delivered everything.
      if (n % 150 == 75) begin
        start <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
        @(posedge clk_i);
      end

      // back-to-back stretch at the start of every hundred
      gap = ((n % 100) < 20) ? 0 : pick_gap();
      issue_request(kind, IDX_W'($urandom), st, ev, ACT_W'($urandom), gap);
    end

    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d directed, %0d random) and %0d results checked.",
             sent, directed_cnt, sent - directed_cnt, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/err_pkg.sv
rtl/err_ram.sv
rtl/event_rule_router_table_unit.sv
rtl/err_checker.sv
dv/event_rule_router_table_unit_chk.sv
dv/tb_event_rule_router_table_unit.sv
